// ----- rtl/jcdl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// jcdl_pkg
// Shared types, constants and the CORDIC angle table for the cd(uK,k) block.
// -----------------------------------------------------------------------------
package jcdl_pkg;

  localparam int LANDEN_STAGES = 8;
  localparam int NUM_MODULI    = 7;
  localparam int NUM_LSTAGES   = (LANDEN_STAGES - 1 > NUM_MODULI) ? NUM_MODULI
                                                                  : LANDEN_STAGES - 1;
  localparam int CORDIC_ITERS  = 30;
  localparam int DIV_STEPS     = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int XW            = 34;

  localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX = CFG_IDX_W'(NUM_MODULI - 1);

  localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [31:0]   ONE_Q30   = 32'sd1073741824;

  // landen stage: 3 multiply cells, 1 setup cell, divide cells, 1 output cell
  localparam int LSTAGE_LAT = 4 + DIV_STEPS + 1;
  localparam int LATENCY    = CORDIC_ITERS + 1 + NUM_LSTAGES * LSTAGE_LAT;

  typedef struct packed {
    logic signed [31:0] angle_u;
    logic               is_last;
  } in_data_t;

  typedef struct packed {
    logic signed [31:0] cd_value;
    logic               last_out;
  } out_data_t;

  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [1:0]           quad;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [31:0]   z;
  } cordic_bus_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic        neg;
    logic [33:0] rem;
    logic [31:0] nlo;
    logic [33:0] d;
    logic [31:0] q;
  } div_bus_t;

  function automatic logic [31:0] atan_quarter(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/jcdl_cordic_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// jcdl_cordic_cell
// One rotation-mode CORDIC iteration with its output register.
// -----------------------------------------------------------------------------
module jcdl_cordic_cell (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [4:0]            iter,
  input  wire jcdl_pkg::cordic_bus_t din,
  output jcdl_pkg::cordic_bus_t      dout
);

  jcdl_pkg::cordic_bus_t    nxt;
  logic signed [jcdl_pkg::XW-1:0] dx, dy;
  logic signed [31:0]       ang;

  always_comb begin
    dx  = din.y >>> iter;
    dy  = din.x >>> iter;
    ang = $signed(jcdl_pkg::atan_quarter(iter));
    nxt = din;
    if (din.z >= 0) begin
      nxt.x = din.x - dx;
      nxt.y = din.y + dy;
      nxt.z = din.z - ang;
    end else begin
      nxt.x = din.x + dx;
      nxt.y = din.y - dy;
      nxt.z = din.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout <= '0;
    end else begin
      dout <= nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/jcdl_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// jcdl_div_cell
// One restoring-division step: one quotient bit per cell.
// -----------------------------------------------------------------------------
module jcdl_div_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire jcdl_pkg::div_bus_t din,
  output jcdl_pkg::div_bus_t      dout
);

  jcdl_pkg::div_bus_t nxt;
  logic [33:0]        t;

  always_comb begin
    t   = {din.rem[32:0], din.nlo[31]};
    nxt = din;
    nxt.nlo = {din.nlo[30:0], 1'b0};
    if (t >= din.d) begin
      nxt.rem = t - din.d;
      nxt.q   = {din.q[30:0], 1'b1};
    end else begin
      nxt.rem = t;
      nxt.q   = {din.q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout <= '0;
    end else begin
      dout <= nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/jcdl_landen_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// jcdl_landen_stage
// One ascending Landen step y' = (1+v)y / (1+v*y*y), pipelined: three multiply
// cells, a setup cell, a chain of divide cells and a saturating output cell.
// -----------------------------------------------------------------------------
module jcdl_landen_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [31:0]        modulus,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  input  wire logic signed [31:0] in_y,
  output logic                    out_valid,
  output logic                    out_last,
  output logic signed [31:0]      out_y
);

  // cell 0: |y| and y squared
  logic        v0_r, l0_r, n0_r;
  logic [30:0] a0_r;
  logic [30:0] y2_r;
  // cell 1: v * y2
  logic        v1_r, l1_r, n1_r;
  logic [30:0] a1_r;
  logic [31:0] vy2_r;
  // cell 2: v * a
  logic        v2_r, l2_r, n2_r;
  logic [31:0] den_r;
  logic [30:0] a2_r;
  logic [62:0] va_r;

  logic [30:0] a_in;
  logic [61:0] sq;
  logic [63:0] vy2_full;
  logic [63:0] nsum;

  jcdl_pkg::div_bus_t div_in_r;
  jcdl_pkg::div_bus_t chain [jcdl_pkg::DIV_STEPS+1];
  jcdl_pkg::div_bus_t last_b;
  logic [31:0]        q_sat;

  always_comb begin
    a_in     = in_y[31] ? 31'(-in_y) : in_y[30:0];
    sq       = a_in * a_in + 62'd536870912;
    vy2_full = {32'd0, modulus} * {33'd0, y2_r} + 64'd2147483648;
    nsum     = {1'b0, a2_r, 32'd0} + 64'(va_r) + {31'd0, den_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      div_in_r <= '0;
    end else begin
      v0_r           <= in_valid;
      v1_r           <= v0_r;
      v2_r           <= v1_r;
      div_in_r.valid <= v2_r;
      div_in_r.last  <= l2_r;
      div_in_r.neg   <= n2_r;
      div_in_r.rem   <= {2'd0, nsum[63:32]};
      div_in_r.nlo   <= nsum[31:0];
      div_in_r.d     <= {den_r, 2'b00};
      div_in_r.q     <= 32'd0;
    end

    l0_r  <= in_last;
    n0_r  <= in_y[31];
    a0_r  <= a_in;
    y2_r  <= sq[60:30];

    l1_r  <= l0_r;
    n1_r  <= n0_r;
    a1_r  <= a0_r;
    vy2_r <= vy2_full[63:32];

    l2_r  <= l1_r;
    n2_r  <= n1_r;
    a2_r  <= a1_r;
    den_r <= 32'd1073741824 + vy2_r;
    va_r  <= {31'd0, modulus} * {32'd0, a1_r};
  end

  assign chain[0] = div_in_r;

  for (genvar g = 0; g < jcdl_pkg::DIV_STEPS; g++) begin : g_div
    jcdl_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  assign last_b = chain[jcdl_pkg::DIV_STEPS];
  assign q_sat  = (last_b.q > 32'd1073741824) ? 32'd1073741824 : last_b.q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= last_b.valid;
    end
    out_last  <= last_b.last;
    out_y     <= last_b.neg ? -$signed(q_sat) : $signed(q_sat);
  end

endmodule
`default_nettype wire

// ----- rtl/jacobi_cd_landen_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// jacobi_cd_landen_top
// Jacobi elliptic cd(uK,k): CORDIC cosine followed by ascending Landen steps.
// -----------------------------------------------------------------------------
// Usage:
//   Drive in_data and pulse start; a beat is taken on any edge with start
//   high, since busy stays low. One beat per clock is sustained.
//   out_valid strobes for one cycle with out_data once a beat has passed
//   the pipeline (30 CORDIC cells, 1 quadrant cell and 37 cells per Landen
//   step, seven steps). The receiver cannot stall; results leave
//   in input order.
//   Moduli are written through cfg_valid/cfg_index/cfg_data (always ready);
//   index 0 holds stage one. Write only while no beat is in flight. Indexes
//   beyond the last modulus are dropped.
//   Reset (rst_n low, synchronous) clears the moduli and all valid bits;
//   beats in flight are lost.
// -----------------------------------------------------------------------------
module jacobi_cd_landen_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire jcdl_pkg::in_data_t                in_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [jcdl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                       cfg_data,
  output logic                                   out_valid,
  output jcdl_pkg::out_data_t                    out_data
);

  logic [31:0] mod_r [jcdl_pkg::NUM_MODULI];

  jcdl_pkg::cordic_bus_t cb [jcdl_pkg::CORDIC_ITERS+1];
  jcdl_pkg::cordic_bus_t cend;

  logic                  ls_v [jcdl_pkg::NUM_LSTAGES+1];
  logic                  ls_l [jcdl_pkg::NUM_LSTAGES+1];
  logic signed [31:0]    ls_y [jcdl_pkg::NUM_LSTAGES+1];

  logic signed [jcdl_pkg::XW-1:0] sel;
  logic signed [31:0]             sel_sat;
  logic                           q_v_r, q_l_r;
  logic signed [31:0]             q_y_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < jcdl_pkg::NUM_MODULI; i++) begin
        mod_r[i] <= 32'd0;
      end
    end else if (cfg_valid && cfg_index <= jcdl_pkg::CFG_LAST_INDEX) begin
      mod_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    cb[0].valid = start;
    cb[0].last  = in_data.is_last;
    cb[0].quad  = in_data.angle_u[29:28];
    cb[0].x     = jcdl_pkg::CORDIC_X0;
    cb[0].y     = '0;
    cb[0].z     = {2'b00, in_data.angle_u[27:0], 2'b00};
  end

  for (genvar g = 0; g < jcdl_pkg::CORDIC_ITERS; g++) begin : g_cordic
    jcdl_cordic_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .iter (5'(g)),
      .din  (cb[g]),
      .dout (cb[g+1])
    );
  end

  assign cend = cb[jcdl_pkg::CORDIC_ITERS];

  // pick cos from the quadrant, then clamp to plus or minus one
  always_comb begin
    case (cend.quad)
      2'd0:    sel = cend.x;
      2'd1:    sel = -cend.y;
      2'd2:    sel = -cend.x;
      default: sel = cend.y;
    endcase
    if (sel > jcdl_pkg::XW'(jcdl_pkg::ONE_Q30)) begin
      sel_sat = jcdl_pkg::ONE_Q30;
    end else if (sel < -jcdl_pkg::XW'(jcdl_pkg::ONE_Q30)) begin
      sel_sat = -jcdl_pkg::ONE_Q30;
    end else begin
      sel_sat = sel[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else begin
      q_v_r <= cend.valid;
    end
    q_l_r <= cend.last;
    q_y_r <= sel_sat;
  end

  assign ls_v[0] = q_v_r;
  assign ls_l[0] = q_l_r;
  assign ls_y[0] = q_y_r;

  // highest stage first, down to stage one
  for (genvar s = 0; s < jcdl_pkg::NUM_LSTAGES; s++) begin : g_landen
    jcdl_landen_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .modulus  (mod_r[jcdl_pkg::NUM_LSTAGES-1-s]),
      .in_valid (ls_v[s]),
      .in_last  (ls_l[s]),
      .in_y     (ls_y[s]),
      .out_valid(ls_v[s+1]),
      .out_last (ls_l[s+1]),
      .out_y    (ls_y[s+1])
    );
  end

  assign out_valid         = ls_v[jcdl_pkg::NUM_LSTAGES];
  assign out_data.cd_value = ls_y[jcdl_pkg::NUM_LSTAGES];
  assign out_data.last_out = ls_l[jcdl_pkg::NUM_LSTAGES];

`ifndef SYNTHESIS
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(jcdl_pkg::LATENCY) out_valid)
    else $error("beat did not come out after fixed latency");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, jcdl_pkg::LATENCY))
    else $error("result without matching input beat");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.cd_value <= jcdl_pkg::ONE_Q30 &&
                   out_data.cd_value >= -jcdl_pkg::ONE_Q30))
    else $error("cd value outside plus or minus one");
`endif

endmodule
`default_nettype wire
